// ===== src/mhck_pkg.sv =====
// shared types and constants for the max-heap change-key block
`timescale 1ns / 1ps
`default_nettype none

package mhck_pkg;

  // default number of heap entries
  localparam int unsigned CAPACITY_DEF = 64;

  // key width
  localparam int unsigned KEY_W = 32;

  // operation selector
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CHANGE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_EMPTY     = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SRCH,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_L,
    ST_DN_R,
    ST_DUMP
  } state_e;

endpackage

`default_nettype wire

// ===== src/mhck_ram.sv =====
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
`default_nettype none

module mhck_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/max_heap_change_key.sv =====
// top level of the binary max-heap with append, change-key and dump
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to CAPACITY signed 32-bit keys as a 1-based binary max-heap in one
// ram with a single write and a single registered read port. One input
// transaction is handled at a time; the next is taken once the last result has
// been placed in the output register. Append, and a change or dump on an empty
// heap, go straight to the result. Change scans the entries one read per cycle,
// then bubbles up a level at a time (read parent, compare and write) or sifts
// down a level at a time (left child, right child, compare). Dump streams one
// entry per cycle while the downstream side is ready. The single ram read port
// sets the pace of all of these steps.
module max_heap_change_key
  import mhck_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input transaction
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] new_key
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] op
  // result transaction
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] value
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  output logic             m_axis_tlast   // last
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [KEY_W-1:0]  new_q, new_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [KEY_W-1:0]  lval_q, lval_d;
  status_e           status_q, status_d;

  logic              out_valid_q, out_valid_d;
  logic [KEY_W-1:0]  out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  logic              in_acc;
  op_e               in_op;
  logic              out_free;
  logic              out_load;
  logic              full;
  logic              hit;
  logic              scan_done;
  logic              issue;
  logic              key_same;
  logic              grow;
  logic              up_move;
  logic [CW:0]       child;
  logic              has_right;
  logic [CW-1:0]     pos_m1;
  logic [CW-1:0]     par_m1;
  logic [CW:0]       child_m1;
  logic [KEY_W-1:0]  cand;
  logic [CW:0]       cand_pos;
  logic              sink;
  logic              dump_last;

  // heap storage
  mhck_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshake and shared decisions
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_e'(s_axis_tuser);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (cnt_q >= CW'(CAPACITY));

  assign issue         = (idx_q < cnt_q);
  assign hit           = pend_q && (ram_rdata == key_q);
  assign scan_done     = !pend_q && (idx_q == cnt_q);
  assign key_same      = (key_q == new_q);
  assign grow          = ($signed(new_q) > $signed(key_q));
  assign up_move       = ($signed(new_q) > $signed(ram_rdata));

  assign pos_m1        = pos_q - 1'b1;
  assign par_m1        = (pos_q >> 1) - 1'b1;
  assign child         = {pos_q, 1'b0};
  assign child_m1      = child - 1'b1;
  assign has_right     = (child < {1'b0, cnt_q});
  assign dump_last     = (idx_q == cnt_q - 1'b1);

  // larger child: right only when strictly greater than left
  always_comb begin
    cand     = ram_rdata;
    cand_pos = child;
    if (state_q == ST_DN_R) begin
      if ($signed(ram_rdata) > $signed(lval_q)) begin
        cand     = ram_rdata;
        cand_pos = child + 1'b1;
      end else begin
        cand     = lval_q;
        cand_pos = child;
      end
    end
  end

  assign sink = ($signed(cand) > $signed(new_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_APPEND: state_d = ST_EMIT;
            OP_CHANGE: state_d = (cnt_q == '0) ? ST_EMIT : ST_SRCH;
            OP_DUMP:   state_d = (cnt_q == '0) ? ST_EMIT : ST_DUMP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_SRCH: begin
        if (hit) begin
          if (key_same)  state_d = ST_EMIT;
          else if (grow) state_d = ST_UP_RD;
          else           state_d = ST_DN_RD;
        end else if (scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_UP_RD:  state_d = (pos_q == CW'(1)) ? ST_EMIT : ST_UP_CMP;
      ST_UP_CMP: state_d = up_move ? ST_UP_RD : ST_EMIT;
      ST_DN_RD:  state_d = (child > {1'b0, cnt_q}) ? ST_EMIT : ST_DN_L;
      ST_DN_L: begin
        if (has_right)  state_d = ST_DN_R;
        else if (sink)  state_d = ST_DN_RD;
        else            state_d = ST_EMIT;
      end
      ST_DN_R:   state_d = sink ? ST_DN_RD : ST_EMIT;
      ST_DUMP: begin
        if (out_free && dump_last) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // ram accesses and result loading
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = pos_m1[AW-1:0];
    ram_wdata    = new_q;
    ram_raddr    = '0;
    out_load     = 1'b0;
    out_value_d  = '0;
    out_status_d = status_q;
    out_last_d   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_APPEND) && !full) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AW-1:0];
          ram_wdata = s_axis_tdata[31:0];
        end
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      ST_SRCH: begin
        ram_raddr = idx_q[AW-1:0];
      end
      ST_UP_RD: begin
        ram_raddr = par_m1[AW-1:0];
        ram_we    = (pos_q == CW'(1));
      end
      ST_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = up_move ? ram_rdata : new_q;
      end
      ST_DN_RD: begin
        ram_raddr = child_m1[AW-1:0];
        ram_we    = (child > {1'b0, cnt_q});
      end
      ST_DN_L: begin
        ram_raddr = child[AW-1:0];
        if (!has_right) begin
          ram_we    = 1'b1;
          ram_wdata = sink ? cand : new_q;
        end
      end
      ST_DN_R: begin
        ram_we    = 1'b1;
        ram_wdata = sink ? cand : new_q;
      end
      ST_DUMP: begin
        ram_raddr    = out_free ? idx_q[AW-1:0] + 1'b1 : idx_q[AW-1:0];
        out_load     = out_free;
        out_value_d  = ram_rdata;
        out_status_d = STS_OK;
        out_last_d   = dump_last;
      end
      default: ;
    endcase
  end

  // working registers next values
  always_comb begin
    cnt_d     = cnt_q;
    key_d     = key_q;
    new_d     = new_q;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    pend_d    = pend_q;
    pos_d     = pos_q;
    lval_d    = lval_q;
    status_d  = status_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          key_d  = s_axis_tdata[31:0];
          new_d  = s_axis_tdata[63:32];
          idx_d  = '0;
          pend_d = 1'b0;
          case (in_op)
            OP_APPEND: begin
              status_d = full ? STS_FULL : STS_OK;
              if (!full) cnt_d = cnt_q + 1'b1;
            end
            OP_CHANGE: status_d = STS_NOT_FOUND;
            OP_DUMP:   status_d = STS_EMPTY;
            default:   status_d = status_q;
          endcase
        end
      end
      ST_SRCH: begin
        idx_d     = issue ? idx_q + 1'b1 : idx_q;
        pend_d    = issue;
        cmp_idx_d = idx_q;
        if (hit) begin
          status_d = STS_OK;
          pos_d    = cmp_idx_q + 1'b1;
        end else if (scan_done) begin
          status_d = STS_NOT_FOUND;
        end
      end
      ST_UP_CMP: begin
        if (up_move) pos_d = pos_q >> 1;
      end
      ST_DN_L: begin
        lval_d = ram_rdata;
        if (!has_right && sink) pos_d = cand_pos[CW-1:0];
      end
      ST_DN_R: begin
        if (sink) pos_d = cand_pos[CW-1:0];
      end
      ST_DUMP: begin
        if (out_free) idx_d = idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  // output register next value
  always_comb begin
    if (out_load)           out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else                    out_valid_d = out_valid_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    new_q     <= new_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    pos_q     <= pos_d;
    lval_q    <= lval_d;
    status_q  <= status_d;
    if (out_load) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // the entry count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // ram writes stay inside the occupied part of the heap or the next free entry
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) < cnt_q || CW'(ram_waddr) == cnt_q))
    else $error("heap write outside occupied entries");

  // the entry count only moves between transactions
  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(cnt_q))
    else $error("entry count changed during an operation");

  // an empty status is only reported for an empty heap
  a_empty_sts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_status_d == STS_EMPTY) |-> (cnt_q == '0))
    else $error("empty status with entries present");

endmodule

`default_nettype wire

// ===== tb/sv/tb_max_heap_change_key.sv =====
// testbench for the max-heap change-key block: directed and random stream traffic checked against a heap model
`timescale 1ns / 1ps

module tb_max_heap_change_key;
  import mhck_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  // one expected result transaction
  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
    logic               last;
  } heap_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] key, [63:32] new_key
  logic [1:0]  s_axis_tuser;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] value
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        m_axis_tlast;

  // heap model state and expected results
  logic signed [31:0] heap_keys [CAP];
  int unsigned        heap_size;
  heap_result_t       pending_results [$];

  // run control and statistics
  bit          idle_en;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  int unsigned op_count [4];
  int unsigned full_count;
  int unsigned not_found_count;
  int unsigned empty_count;

  max_heap_change_key #(
    .CAPACITY(CAP)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // append one expectation at the tail of the queue
  function automatic void push_result(logic signed [31:0] value, status_e status, logic last);
    heap_result_t item;
    item = '{value: value, status: status, last: last};
    pending_results = {pending_results, item};
  endfunction

  // find the first matching key, replace it and restore order around it
  function automatic status_e change_heap_key(logic signed [31:0] old_key,
                                              logic signed [31:0] new_key);
    int unsigned pos;
    int unsigned child;
    logic signed [31:0] child_key;
    bit done;
    pos = 0;
    for (int unsigned i = 1; i <= heap_size; i++) begin
      if (heap_keys[i-1] == old_key) begin
        pos = i;
        break;
      end
    end
    if (pos == 0) return STS_NOT_FOUND;
    if (old_key == new_key) return STS_OK;
    if (new_key > old_key) begin
      // bubble up while the parent is smaller
      while (pos > 1 && new_key > heap_keys[pos/2-1]) begin
        heap_keys[pos-1] = heap_keys[pos/2-1];
        pos = pos / 2;
      end
    end else begin
      // sift down; right child only when strictly greater than left
      done = 1'b0;
      while (!done) begin
        child = 2 * pos;
        if (child > heap_size) begin
          done = 1'b1;
        end else begin
          child_key = heap_keys[child-1];
          if (child + 1 <= heap_size && heap_keys[child] > child_key) begin
            child++;
            child_key = heap_keys[child-1];
          end
          if (child_key > new_key) begin
            heap_keys[pos-1] = child_key;
            pos = child;
          end else begin
            done = 1'b1;
          end
        end
      end
    end
    heap_keys[pos-1] = new_key;
    return STS_OK;
  endfunction

  // update the heap model for one accepted transaction and queue its results
  function automatic void predict_heap_op(logic [1:0] op, logic signed [31:0] key,
                                          logic signed [31:0] new_key);
    status_e sts;
    op_count[op]++;
    case (op)
      OP_APPEND: begin
        if (heap_size >= CAP) begin
          full_count++;
          push_result('0, STS_FULL, 1'b1);
        end else begin
          heap_keys[heap_size] = key;
          heap_size++;
          push_result('0, STS_OK, 1'b1);
        end
      end
      OP_CHANGE: begin
        sts = change_heap_key(key, new_key);
        if (sts == STS_NOT_FOUND) not_found_count++;
        push_result('0, sts, 1'b1);
      end
      OP_DUMP: begin
        if (heap_size == 0) begin
          empty_count++;
          push_result('0, STS_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < heap_size; i++)
            push_result(heap_keys[i], STS_OK, i == heap_size - 1);
        end
      end
      default: ;
    endcase
  endfunction

  // drive one input transaction and wait for it to be taken
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] key,
                           input logic signed [31:0] new_key);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {new_key, key};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_heap_op(op, key, new_key);
    @(negedge clk_i);
  endtask

  // empty heap: dump, change of absent keys, reserved selector
  task automatic test_empty_heap();
    send_item(OP_DUMP, $urandom, $urandom);
    send_item(OP_CHANGE, 32'sd0, 32'sd0);
    send_item(OP_CHANGE, 32'sd5, 32'sd7);
    send_item(OP_RESERVED, $urandom, $urandom);
  endtask

  // small heap: sift down with equal children, bubble up, extremes, no-op changes
  task automatic test_basic_ops();
    send_item(OP_APPEND, 32'sd100, 32'sd0);
    send_item(OP_APPEND, 32'sd50, 32'sd0);
    send_item(OP_APPEND, 32'sd50, 32'sd0);
    send_item(OP_APPEND, 32'sd10, 32'sd0);
    send_item(OP_APPEND, 32'sd20, 32'sd0);
    send_item(OP_APPEND, 32'sd30, 32'sd0);
    send_item(OP_APPEND, 32'sd40, 32'sd0);
    send_item(OP_CHANGE, 32'sd100, 32'sd5);
    send_item(OP_CHANGE, 32'sd10, KEY_MAX);
    send_item(OP_CHANGE, 32'sd50, 32'sd50);
    send_item(OP_CHANGE, 32'sd999, 32'sd999);
    send_item(OP_CHANGE, KEY_MAX, KEY_MIN);
    send_item(OP_DUMP, 32'sd0, 32'sd0);
    send_item(OP_APPEND, KEY_MIN, KEY_MAX);
    send_item(OP_APPEND, KEY_MAX, KEY_MIN);
    send_item(OP_RESERVED, KEY_MAX, KEY_MIN);
    send_item(OP_DUMP, 32'sd0, 32'sd0);
  endtask

  // random traffic: mostly heap-ordered appends and changes of stored keys
  task automatic test_random_mix();
    int unsigned pick;
    int unsigned sel;
    logic [1:0] op;
    logic signed [31:0] key;
    logic signed [31:0] new_key;
    longint near;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) idle_en = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 99);
      key = $urandom;
      new_key = $urandom;
      if (pick < 4) begin
        op = OP_RESERVED;
      end else if (pick < 12) begin
        op = OP_DUMP;
      end else if (pick < 60) begin
        op = OP_APPEND;
        sel = $urandom_range(0, 99);
        if (heap_size > 0 && heap_size < CAP && sel >= 15) begin
          // stay at or below the parent so the heap stays ordered
          near = longint'(heap_keys[(heap_size + 1) / 2 - 1]) - $urandom_range(0, 3000);
          if (near < longint'(KEY_MIN)) near = longint'(KEY_MIN);
          key = near[31:0];
        end else if (sel < 5) begin
          key = (sel[0]) ? KEY_MAX : KEY_MIN;
        end
      end else begin
        op = OP_CHANGE;
        if (heap_size > 0 && $urandom_range(0, 99) < 85)
          key = heap_keys[$urandom_range(0, heap_size - 1)];
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          new_key = key;
        end else if (sel == 1) begin
          new_key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        end else if (sel >= 5) begin
          near = longint'(key) + $urandom_range(0, 10000) - 5000;
          if (near > longint'(KEY_MAX)) near = longint'(KEY_MAX);
          if (near < longint'(KEY_MIN)) near = longint'(KEY_MIN);
          new_key = near[31:0];
        end
      end
      send_item(op, key, new_key);
    end
    s_axis_tvalid = 1'b0;
  endtask

  // result side: random stall before each result
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = idle_en ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    heap_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result value=%0d status=%0d last=%0b", $time,
                   $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser !== want.status ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: result mismatch exp value=%0d status=%0d last=%0b, ",
                      "got value=%0d status=%0d last=%0b"},
                     $time, want.value, want.status, want.last,
                     $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("** max_heap_change_key: FAILED **");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    idle_en = 1'b1;
    heap_size = 0;
    mismatches = 0;
    results_seen = 0;
    quiet_cycles = 0;
    full_count = 0;
    not_found_count = 0;
    empty_count = 0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_heap();
    idle_en = 1'b0;
    test_basic_ops();
    idle_en = 1'b1;
    test_random_mix();

    // drain outstanding results, then allow for stray late output
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d appends (%0d full), %0d changes (%0d not found), %0d dumps (%0d empty)",
             op_count[OP_APPEND], full_count, op_count[OP_CHANGE], not_found_count,
             op_count[OP_DUMP], empty_count);
    $display("%0d reserved selectors ignored, %0d results checked, %0d mismatches",
             op_count[OP_RESERVED], results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** max_heap_change_key: PASSED **");
    end else begin
      $display("** max_heap_change_key: FAILED **");
    end
    $finish;
  end

endmodule

// ===== max_heap_change_key.f =====
src/mhck_pkg.sv
src/mhck_ram.sv
src/max_heap_change_key.sv
tb/sv/tb_max_heap_change_key.sv
